// File: hw/rtl/fcw_pkg.sv
// shared types, constants and helper functions for the fat32 cluster chain walker
// no dependencies; every other file imports this package
package fcw_pkg;

	localparam int CLUSTER_W = 28;
	localparam int LBA_W     = 32;
	localparam int SEC_W     = 8;
	localparam int IDX_W     = 7;
	localparam int POWER_W   = CLUSTER_W + 1;
	localparam int CFG_IDX_W = 2;

	localparam int MAX_SECTORS_PER_CLUSTER = 128;
	localparam int ENTRY_SHIFT             = IDX_W;

	localparam logic [CLUSTER_W-1:0] CLUSTER_LIMIT = 28'h0ffffff0;
	localparam logic [CLUSTER_W-1:0] EOC_MIN       = 28'h0ffffff8;
	localparam logic [POWER_W-1:0]   POWER_CAP     = 29'h10000000;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		ACT_START   = 2'd0,
		ACT_LINK    = 2'd1,
		ACT_ADVANCE = 2'd2,
		ACT_NOP     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_LINK = 2'd1,
		ST_EOC  = 2'd2,
		ST_ERR  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAT_START  = 2'd0,
		REG_DATA_START = 2'd1,
		REG_TOTAL      = 2'd2,
		REG_SECTORS    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [LBA_W-1:0]     fat_start_lba;
		logic [LBA_W-1:0]     data_start_lba;
		logic [CLUSTER_W-1:0] total_clusters;
		logic [SEC_W-1:0]     cluster_sectors;
	} cfg_t;

	// classified item, as queued between front and exec
	typedef struct packed {
		action_t              act;
		logic [CLUSTER_W-1:0] word;
		logic                 word_ok;
		logic                 word_eoc;
	} cmd_t;

	typedef struct packed {
		status_t              status;
		logic [CLUSTER_W-1:0] cluster;
		logic [SEC_W-1:0]     sector;
	} res_t;

	function automatic logic cluster_in_range(input logic [CLUSTER_W-1:0] c,
			input logic [CLUSTER_W-1:0] total);
		logic [CLUSTER_W-1:0] rel;
		rel = c - CLUSTER_W'(2);
		return (c >= CLUSTER_W'(2)) && (rel < total) && (c < CLUSTER_LIMIT);
	endfunction

	// zero counts as one, large values clamp to the maximum
	function automatic logic [SEC_W-1:0] eff_sectors(input logic [SEC_W-1:0] cs);
		logic [SEC_W-1:0] s;
		s = cs;
		if (s == '0) s = SEC_W'(1);
		if (s > SEC_W'(MAX_SECTORS_PER_CLUSTER)) s = SEC_W'(MAX_SECTORS_PER_CLUSTER);
		return s;
	endfunction

endpackage

// File: hw/rtl/fcw_if.sv
// handshake channel interfaces: input items, result items and register writes
// depends on fcw_pkg for field widths
interface fcw_item_if import fcw_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       action;
	logic [LBA_W-1:0] value;

	modport source (output valid, action, value, input ready);
	modport sink (input valid, action, value, output ready);
endinterface

interface fcw_result_if import fcw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           status;
	logic [CLUSTER_W-1:0] cluster;
	logic [LBA_W-1:0]     data_lba;
	logic [LBA_W-1:0]     fat_lba;
	logic [IDX_W-1:0]     fat_index;

	modport source (output valid, status, cluster, data_lba, fat_lba, fat_index, input ready);
	modport sink (input valid, status, cluster, data_lba, fat_lba, fat_index, output ready);
endinterface

interface fcw_cfg_if import fcw_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [LBA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/fat32_cluster_chain_walker_core.sv
// top level of the fat32 cluster chain walker: register file, front, exec and address stages
// depends on fcw_pkg, the fcw interfaces, fcw_front, fcw_exec and fcw_addr
//
// usage:
// - in carries one item per transaction: action (start, link, advance) and a 32-bit value
// - out carries one result per item: status, cluster, data sector, fat sector and entry index
// - cfg writes the four volume registers by index; it is always ready and should only be
//   used while no item is in flight
// - an accepted item is queued in a two-entry queue and executed by the exec stage when it
//   can take it; its result passes the exec result register and the output register to out
// - throughput is one item per clock while out does not stall, set by the exec state update
// - when out stalls, the output register and the exec result register hold, then the queue
//   fills and in.ready drops; nothing is lost or repeated
// - reset clears the walk state (cluster 0, no link pending, no error), the queue and the
//   output valid, and sets the registers to 0, 0, 0 and one sector per cluster
// - errors are sticky until the next start item
module fat32_cluster_chain_walker_core import fcw_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	fcw_item_if.sink     in,
	fcw_result_if.source out,
	fcw_cfg_if.sink      cfg
);

	cfg_t regs_q;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;
	res_t res_s1;
	logic res_valid_s1;
	logic res_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.fat_start_lba   <= '0;
			regs_q.data_start_lba  <= '0;
			regs_q.total_clusters  <= '0;
			regs_q.cluster_sectors <= SEC_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_FAT_START:  regs_q.fat_start_lba   <= cfg.data;
				REG_DATA_START: regs_q.data_start_lba  <= cfg.data;
				REG_TOTAL:      regs_q.total_clusters  <= cfg.data[CLUSTER_W-1:0];
				REG_SECTORS:    regs_q.cluster_sectors <= cfg.data[SEC_W-1:0];
				default: ;
			endcase
		end
	end

	fcw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in),
		.cfg       (regs_q),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	fcw_exec u_exec (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (regs_q),
		.cmd          (cmd),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.res_s1       (res_s1),
		.res_valid_s1 (res_valid_s1),
		.res_ready    (res_ready)
	);

	fcw_addr u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (regs_q),
		.res_s1       (res_s1),
		.res_valid_s1 (res_valid_s1),
		.res_ready    (res_ready),
		.out          (out)
	);

	// a result waiting for the address stage must not change or vanish
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s1 && !res_ready |=> res_valid_s1 && $stable(res_s1))
		else $error("exec result changed while stalled");

	// a new output only follows a handoff from the exec stage
	a_out_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out.valid) |-> $past(res_valid_s1 && res_ready))
		else $error("output valid without exec handoff");

	// the exec stage never consumes from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready && !cmd_valid |=> !res_valid_s1 || $past(!res_ready && res_valid_s1))
		else $error("result produced without a queued command");

endmodule

// File: hw/rtl/fcw_front.sv
// front end: accepts input items, classifies the word and queues commands
// depends on fcw_pkg and fcw_item_if
module fcw_front import fcw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	fcw_item_if.sink  in,
	input  cfg_t      cfg,
	output cmd_t      cmd,
	output logic      cmd_valid,
	input  logic      cmd_ready
);

	cmd_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              cls;
	logic              push;
	logic              pop;
	logic              in_rng;

	always_comb begin
		cls.act  = action_t'(in.action);
		cls.word = in.value[CLUSTER_W-1:0];
		in_rng   = cluster_in_range(cls.word, cfg.total_clusters);
		// a start checks the unmasked value, a link only the masked word
		if (cls.act == ACT_START) begin
			cls.word_ok = (in.value[LBA_W-1:CLUSTER_W] == '0) && in_rng;
		end else begin
			cls.word_ok = in_rng;
		end
		cls.word_eoc = cls.word >= EOC_MIN;
	end

	assign in.ready  = count_q != QCNT_W'(QDEPTH);
	assign cmd_valid = count_q != '0;
	assign cmd       = q_mem_q[rd_ptr_q];
	assign push      = in.valid && in.ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

endmodule

// File: hw/rtl/fcw_exec.sv
// exec stage: walk state, brent loop check, step limit and sticky error
// depends on fcw_pkg; takes commands from the front queue
module fcw_exec import fcw_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  cmd_t cmd,
	input  logic cmd_valid,
	output logic cmd_ready,
	output res_t res_s1,
	output logic res_valid_s1,
	input  logic res_ready
);

	logic [CLUSTER_W-1:0] cur_q, anchor_q, len_q, step_q;
	logic [POWER_W-1:0]   power_q;
	logic [SEC_W-1:0]     sec_q;
	logic                 lp_q, err_q;

	logic [CLUSTER_W-1:0] cur_n, anchor_n, len_n, step_n;
	logic [POWER_W-1:0]   power_n;
	logic [SEC_W-1:0]     sec_n;
	logic                 lp_n, err_n;
	status_t              status;

	logic                 cur_ok;
	logic [CLUSTER_W-1:0] step_inc;
	logic [POWER_W-1:0]   len_inc;
	logic [SEC_W:0]       sec_inc;
	logic [SEC_W-1:0]     eff;
	logic                 fire;

	assign cmd_ready = !res_valid_s1 || res_ready;
	assign fire      = cmd_valid && cmd_ready;

	always_comb begin
		cur_n    = cur_q;
		anchor_n = anchor_q;
		len_n    = len_q;
		step_n   = step_q;
		power_n  = power_q;
		sec_n    = sec_q;
		lp_n     = lp_q;
		err_n    = err_q;
		status   = ST_OK;
		cur_ok   = cluster_in_range(cur_q, cfg.total_clusters);
		step_inc = step_q + CLUSTER_W'(1);
		len_inc  = {1'b0, len_q} + POWER_W'(1);
		sec_inc  = {1'b0, sec_q} + (SEC_W+1)'(1);
		eff      = eff_sectors(cfg.cluster_sectors);
		if (cmd.act == ACT_START) begin
			cur_n    = cmd.word;
			anchor_n = cmd.word;
			power_n  = POWER_W'(1);
			len_n    = '0;
			step_n   = '0;
			sec_n    = '0;
			lp_n     = 1'b0;
			err_n    = !cmd.word_ok;
			status   = cmd.word_ok ? ST_OK : ST_ERR;
		end else if (err_q) begin
			status = ST_ERR;
		end else begin
			case (cmd.act)
				ACT_LINK: begin
					if (!lp_q) begin
						status = ST_OK;
					end else if (!cur_ok) begin
						err_n  = 1'b1;
						status = ST_ERR;
					end else if (cmd.word_eoc) begin
						status = ST_EOC;
					end else if (!cmd.word_ok) begin
						err_n  = 1'b1;
						status = ST_ERR;
					end else begin
						step_n = step_inc;
						if (step_inc >= cfg.total_clusters || cmd.word == anchor_q) begin
							err_n  = 1'b1;
							status = ST_ERR;
						end else begin
							// brent: move the anchor when the run reaches the power
							if (len_inc == power_q) begin
								anchor_n = cmd.word;
								len_n    = '0;
								if (power_q < POWER_CAP) power_n = {power_q[POWER_W-2:0], 1'b0};
							end else begin
								len_n = len_inc[CLUSTER_W-1:0];
							end
							cur_n  = cmd.word;
							sec_n  = '0;
							lp_n   = 1'b0;
							status = ST_OK;
						end
					end
				end
				ACT_ADVANCE: begin
					if (lp_q) begin
						status = ST_LINK;
					end else if (!cur_ok) begin
						err_n  = 1'b1;
						status = ST_ERR;
					end else if (sec_inc >= {1'b0, eff}) begin
						lp_n   = 1'b1;
						status = ST_LINK;
					end else begin
						sec_n  = sec_inc[SEC_W-1:0];
						status = ST_OK;
					end
				end
				default: begin
					status = lp_q ? ST_LINK : ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q        <= '0;
			anchor_q     <= '0;
			power_q      <= POWER_W'(1);
			len_q        <= '0;
			step_q       <= '0;
			sec_q        <= '0;
			lp_q         <= 1'b0;
			err_q        <= 1'b0;
			res_valid_s1 <= 1'b0;
		end else begin
			if (fire) begin
				cur_q    <= cur_n;
				anchor_q <= anchor_n;
				power_q  <= power_n;
				len_q    <= len_n;
				step_q   <= step_n;
				sec_q    <= sec_n;
				lp_q     <= lp_n;
				err_q    <= err_n;
			end
			if (cmd_ready) begin
				res_valid_s1 <= cmd_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1.status  <= status;
			res_s1.cluster <= cur_n;
			res_s1.sector  <= sec_n;
		end
	end

endmodule

// File: hw/rtl/fcw_addr.sv
// address stage: data sector, fat sector and entry index, held in the output register
// depends on fcw_pkg and fcw_result_if
module fcw_addr import fcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  res_t        res_s1,
	input  logic        res_valid_s1,
	output logic        res_ready,
	fcw_result_if.source out
);

	logic [LBA_W-1:0]       offs;
	logic [LBA_W-1:0]       prod;
	logic [LBA_W-1:0]       data_lba;
	logic [LBA_W-1:0]       fat_lba;
	logic                   valid_q;
	logic [1:0]             status_q;
	logic [CLUSTER_W-1:0]   cluster_q;
	logic [LBA_W-1:0]       data_lba_q;
	logic [LBA_W-1:0]       fat_lba_q;
	logic [IDX_W-1:0]       fat_index_q;
	logic                   load;

	always_comb begin
		// cluster minus two wraps like the 32-bit address math
		offs     = {{(LBA_W-CLUSTER_W){1'b0}}, res_s1.cluster} - LBA_W'(2);
		prod     = offs * {{(LBA_W-SEC_W){1'b0}}, eff_sectors(cfg.cluster_sectors)};
		data_lba = cfg.data_start_lba + prod
			+ {{(LBA_W-SEC_W){1'b0}}, res_s1.sector};
		fat_lba  = cfg.fat_start_lba
			+ {{(LBA_W-CLUSTER_W+ENTRY_SHIFT){1'b0}}, res_s1.cluster[CLUSTER_W-1:ENTRY_SHIFT]};
	end

	assign res_ready = !valid_q || out.ready;
	assign load      = res_valid_s1 && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			status_q    <= res_s1.status;
			cluster_q   <= res_s1.cluster;
			data_lba_q  <= data_lba;
			fat_lba_q   <= fat_lba;
			fat_index_q <= res_s1.cluster[IDX_W-1:0];
		end
	end

	assign out.valid     = valid_q;
	assign out.status    = status_q;
	assign out.cluster   = cluster_q;
	assign out.data_lba  = data_lba_q;
	assign out.fat_lba   = fat_lba_q;
	assign out.fat_index = fat_index_q;

endmodule
